// File: rtl/bfiq_pkg.sv
`default_nettype none

package bfiq_pkg;

  // Store geometry. The bit store is kept as words of WORD_BITS bits.
  localparam int MAX_BYTES = 4096;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int MEM_DEPTH = (MAX_BYTES * 8) / WORD_BITS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int POS_W     = $clog2(MAX_BYTES * 8);
  localparam int N_W       = POS_W + 1;

  // Field and register widths.
  localparam int OP_W    = 2;
  localparam int HASH_W  = 32;
  localparam int FB_W    = 13;
  localparam int NP_W    = 8;
  localparam int CIDX_W  = 2;

  // Hashing constants.
  localparam int ROT_RIGHT   = 17;
  localparam int PROBE_LIMIT = 30;
  localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);

  // Remainder unit works on a dividend one bit wider than the hash so that
  // it can reduce 2^32 as well.
  localparam int DIV_W = HASH_W + 1;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_FILTER_BYTES = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_NUM_PROBES   = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [FB_W-1:0] FB_RESET = 13'd8;
  localparam logic [NP_W-1:0] NP_RESET = 8'd6;

  typedef struct packed {
    logic             load;
    logic [DIV_W-1:0] dividend;
    logic [N_W-1:0]   divisor;
  } rem_req_t;

  typedef struct packed {
    logic           done;
    logic [N_W-1:0] rem;
  } rem_rsp_t;

endpackage

`default_nettype wire

// File: rtl/bloom_filter_insert_query.sv
`default_nettype none

// Channel   Handshake                 Payload
// -------   -----------------------   ----------------------------------
// command   start, busy               op, key_hash
// result    done (one-cycle strobe)   may_match
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// A command item is taken when start is high and busy is low.
// An insert or query that probes the store first makes three reductions modulo
// the bit count in the shared remainder unit, then for each probe a word read,
// the test or set, and the two-step update of the probe position.
// A clear, and the clearing pass that follows reset, write one store word a
// cycle over all 1024 store words, with busy high throughout.
// Queries that need no probe, and items that do nothing, finish at once.
// The result strobe cannot be stalled; a result is shown for one cycle.
module bloom_filter_insert_query (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bfiq_pkg::OP_W-1:0]     op,
  input  wire logic [bfiq_pkg::HASH_W-1:0]   key_hash,
  output logic                               done,
  output logic                               may_match,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bfiq_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [bfiq_pkg::FB_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD_H,
    S_MOD_D,
    S_MOD_W,
    S_RD,
    S_CHK,
    S_ADV,
    S_WRAP
  } state_t;

  state_t state;

  // Configuration registers.
  logic [bfiq_pkg::FB_W-1:0] filter_bytes;
  logic [bfiq_pkg::NP_W-1:0] num_probes;

  // Per-item working registers. The probe position is kept as a remainder
  // modulo the bit count: r advances by delta mod n, and whenever the 32-bit
  // hash sum wraps it falls back by 2^32 mod n.
  logic                           op_ins;
  logic [bfiq_pkg::HASH_W-1:0]    hcur;
  logic [bfiq_pkg::HASH_W-1:0]    delta;
  logic [bfiq_pkg::N_W-1:0]       r;
  logic [bfiq_pkg::N_W-1:0]       d;
  logic [bfiq_pkg::N_W-1:0]       w;
  logic                           wrap;
  logic [bfiq_pkg::PROBE_W-1:0]   left;
  logic [bfiq_pkg::ADDR_W-1:0]    caddr;

  logic [bfiq_pkg::N_W-1:0]       nbits;
  logic                           accept;
  logic                           launch;
  logic                           np_zero;
  logic                           np_over;
  logic [bfiq_pkg::PROBE_W-1:0]   ins_count;

  bfiq_pkg::rem_req_t             rem_req;
  bfiq_pkg::rem_rsp_t             rem_rsp;

  logic                           mem_we;
  logic [bfiq_pkg::ADDR_W-1:0]    mem_waddr;
  logic [bfiq_pkg::WORD_BITS-1:0] mem_wdata;
  logic [bfiq_pkg::ADDR_W-1:0]    mem_raddr;
  logic [bfiq_pkg::WORD_BITS-1:0] mem_rdata;
  logic [bfiq_pkg::WORD_BITS-1:0] bit_mask;
  logic                           bit_hit;

  logic [bfiq_pkg::N_W:0]         adv_sum;
  logic [bfiq_pkg::N_W-1:0]       adv_red;
  logic [bfiq_pkg::HASH_W:0]      hash_sum;
  logic [bfiq_pkg::N_W:0]         wrap_up;
  logic [bfiq_pkg::N_W-1:0]       wrap_val;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Number of bits in use: the byte count, capped at the store size, times 8.
  always_comb begin
    if (32'(filter_bytes) > 32'(bfiq_pkg::MAX_BYTES)) begin
      nbits = bfiq_pkg::N_W'(bfiq_pkg::MAX_BYTES * 8);
    end else begin
      nbits = bfiq_pkg::N_W'({filter_bytes, 3'b000});
    end
  end

  assign np_zero = (num_probes == '0);
  assign np_over = (num_probes > bfiq_pkg::NP_W'(bfiq_pkg::PROBE_LIMIT));

  // Inserts that probe the store make at least one probe and at most the probe limit.
  always_comb begin
    if (np_zero) begin
      ins_count = bfiq_pkg::PROBE_W'(1);
    end else if (np_over) begin
      ins_count = bfiq_pkg::PROBE_W'(bfiq_pkg::PROBE_LIMIT);
    end else begin
      ins_count = num_probes[bfiq_pkg::PROBE_W-1:0];
    end
  end

  // An item goes to the probe sequence only if the filter is not empty and,
  // for a query, the probe count is within range and not zero.
  assign launch = (nbits != '0) &&
                  ((op == bfiq_pkg::OP_INSERT) ||
                   ((op == bfiq_pkg::OP_QUERY) && !np_zero && !np_over));

  // Requests to the shared remainder unit: the hash, then the step, then 2^32.
  always_comb begin
    rem_req.load     = 1'b0;
    rem_req.dividend = {1'b0, key_hash};
    rem_req.divisor  = nbits;
    case (state)
      S_IDLE: begin
        rem_req.load = accept && launch;
      end
      S_MOD_H: begin
        rem_req.load     = rem_rsp.done;
        rem_req.dividend = {1'b0, delta};
      end
      S_MOD_D: begin
        rem_req.load     = rem_rsp.done;
        rem_req.dividend = bfiq_pkg::DIV_W'(1) << bfiq_pkg::HASH_W;
      end
      default: begin
        rem_req.load = 1'b0;
      end
    endcase
  end

  bfiq_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  // Store access: the clear sweep writes zeros, an insert writes back the
  // word it read with the probed bit set.
  assign mem_raddr = r[bfiq_pkg::POS_W-1:bfiq_pkg::BIT_W];
  assign bit_mask  = bfiq_pkg::WORD_BITS'(1) << r[bfiq_pkg::BIT_W-1:0];
  assign bit_hit   = ((mem_rdata & bit_mask) != '0);

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = caddr;
      mem_wdata = '0;
    end else begin
      mem_we    = (state == S_CHK) && op_ins;
      mem_waddr = mem_raddr;
      mem_wdata = mem_rdata | bit_mask;
    end
  end

  bfiq_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Probe position update. Both r and d are below n, so one subtract keeps
  // the sum in range. When the hash sum wraps, 2^32 mod n is taken back.
  always_comb begin
    adv_sum  = {1'b0, r} + {1'b0, d};
    if (adv_sum >= {1'b0, nbits}) begin
      adv_red = bfiq_pkg::N_W'(adv_sum - {1'b0, nbits});
    end else begin
      adv_red = adv_sum[bfiq_pkg::N_W-1:0];
    end
    hash_sum = {1'b0, hcur} + {1'b0, delta};
    wrap_up  = {1'b0, r} + {1'b0, nbits};
    if (r >= w) begin
      wrap_val = r - w;
    end else begin
      wrap_val = bfiq_pkg::N_W'(wrap_up - {1'b0, w});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bytes <= bfiq_pkg::FB_RESET;
      num_probes   <= bfiq_pkg::NP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bfiq_pkg::CFG_FILTER_BYTES: filter_bytes <= cfg_data;
        bfiq_pkg::CFG_NUM_PROBES:   num_probes   <= cfg_data[bfiq_pkg::NP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, with the result strobe and value as registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      caddr     <= '0;
      done      <= 1'b0;
      may_match <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          caddr <= caddr + 1'b1;
          if (caddr == {bfiq_pkg::ADDR_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_ins <= (op == bfiq_pkg::OP_INSERT);
            hcur   <= key_hash;
            delta  <= {key_hash[bfiq_pkg::ROT_RIGHT-1:0],
                       key_hash[bfiq_pkg::HASH_W-1:bfiq_pkg::ROT_RIGHT]};
            left   <= (op == bfiq_pkg::OP_INSERT) ? ins_count
                                                  : num_probes[bfiq_pkg::PROBE_W-1:0];
            if (op == bfiq_pkg::OP_CLEAR) begin
              caddr <= '0;
              state <= S_CLEAR;
            end else if (launch) begin
              state <= S_MOD_H;
            end else if (op == bfiq_pkg::OP_QUERY) begin
              // Empty filter never matches; zero or too many probes always do.
              done      <= 1'b1;
              may_match <= (nbits != '0);
            end
          end
        end
        S_MOD_H: begin
          if (rem_rsp.done) begin
            r     <= rem_rsp.rem;
            state <= S_MOD_D;
          end
        end
        S_MOD_D: begin
          if (rem_rsp.done) begin
            d     <= rem_rsp.rem;
            state <= S_MOD_W;
          end
        end
        S_MOD_W: begin
          if (rem_rsp.done) begin
            w     <= rem_rsp.rem;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (!op_ins && !bit_hit) begin
            done      <= 1'b1;
            may_match <= 1'b0;
            state     <= S_IDLE;
          end else if (left == bfiq_pkg::PROBE_W'(1)) begin
            if (!op_ins) begin
              done      <= 1'b1;
              may_match <= 1'b1;
            end
            state <= S_IDLE;
          end else begin
            left  <= left - 1'b1;
            state <= S_ADV;
          end
        end
        S_ADV: begin
          r     <= adv_red;
          hcur  <= hash_sum[bfiq_pkg::HASH_W-1:0];
          wrap  <= hash_sum[bfiq_pkg::HASH_W];
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (wrap) begin
            r <= wrap_val;
          end
          state <= S_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/bfiq_rem.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle, MSB first.
module bfiq_rem (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bfiq_pkg::rem_req_t req,
  output bfiq_pkg::rem_rsp_t     rsp
);

  logic                           running;
  logic                           done;
  logic [bfiq_pkg::CNT_W-1:0]     cnt;
  logic [bfiq_pkg::DIV_W-1:0]     shreg;
  logic [bfiq_pkg::N_W-1:0]       r;
  logic [bfiq_pkg::N_W-1:0]       divisor;
  logic [bfiq_pkg::N_W:0]         trial;
  logic [bfiq_pkg::N_W-1:0]       r_next;

  // The partial remainder stays below the divisor, so the shifted value
  // stays below twice the divisor and one subtract restores it.
  always_comb begin
    trial = {r, shreg[bfiq_pkg::DIV_W-1]};
    if (trial >= {1'b0, divisor}) begin
      r_next = bfiq_pkg::N_W'(trial - {1'b0, divisor});
    end else begin
      r_next = trial[bfiq_pkg::N_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.load) begin
        running <= 1'b1;
        cnt     <= bfiq_pkg::CNT_W'(bfiq_pkg::DIV_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == bfiq_pkg::CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      shreg   <= req.dividend;
      r       <= '0;
      divisor <= req.divisor;
    end else if (running) begin
      shreg <= shreg << 1;
      r     <= r_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = r;

endmodule

`default_nettype wire

// File: rtl/bfiq_ram.sv
`default_nettype none

// Bit store, one word written and one word read per cycle, read data registered.
module bfiq_ram (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [bfiq_pkg::ADDR_W-1:0]    waddr,
  input  wire logic [bfiq_pkg::WORD_BITS-1:0] wdata,
  input  wire logic [bfiq_pkg::ADDR_W-1:0]    raddr,
  output logic      [bfiq_pkg::WORD_BITS-1:0] rdata
);

  logic [bfiq_pkg::WORD_BITS-1:0] mem [bfiq_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
